// ===== hdl/ple_pkg.sv =====
package ple_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  // Broadcast to every cell of the chain for one request
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [SLOT_W-1:0] slot;
  } cell_cmd_t;

endpackage

// ===== hdl/ple_cell.sv =====
module ple_cell (
  input  logic                         clk,
  input  ple_pkg::cell_cmd_t           cmd,
  input  logic [ple_pkg::SLOT_W-1:0]   idx,
  input  logic [ple_pkg::DATA_W-1:0]   new_data,
  input  logic [ple_pkg::DATA_W-1:0]   left_q,
  input  logic [ple_pkg::DATA_W-1:0]   right_q,
  output logic [ple_pkg::DATA_W-1:0]   q
);
  import ple_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      // open a gap at the slot: cells behind it take from the front neighbour
      if (idx > cmd.slot) begin
        data_nxt = left_q;
      end else if (idx == cmd.slot) begin
        data_nxt = new_data;
      end
    end else if (cmd.rem) begin
      // close the gap: cells from the slot onward take from the back neighbour
      if (idx >= cmd.slot) begin
        data_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Ordered list of up to DEPTH entries held in a chain of cells, one entry per
// cell. Requests insert, remove or read at a one-based position. On an
// accepted valid insert or remove, the cells from the slot onward shift
// toward or from their neighbour in parallel; for every accepted request the
// status, read data and new count are registered. A new request is taken in
// every cycle in which the output register is empty or its result is being
// taken, so the sustained rate is one request per cycle while out_tready
// stays high. Entries need no clearing after reset; only positions up to the
// count are ever read.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position [4:0], entry_data [36:5], zero [39:37]
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status [1:0], read_data [33:2], count [38:34], zero [39]
);
  import ple_pkg::*;

  kind_t              kind;
  logic [POS_W-1:0]   position;
  logic [DATA_W-1:0]  entry_data;
  logic               in_acc;

  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;

  logic               out_valid_r;
  status_t            status_r;
  status_t            status_nxt;
  logic [DATA_W-1:0]  rdata_r;
  logic [DATA_W-1:0]  rdata_nxt;
  logic [CNT_W-1:0]   ocnt_r;

  logic [CNT_W:0]     pos_ext;
  logic [CNT_W:0]     cnt_ext;
  logic               ins_pos_ok;
  logic               at_pos_ok;
  logic               full;
  cell_cmd_t          cmd;
  logic [DATA_W-1:0]  cell_q [DEPTH];

  assign kind       = kind_t'(in_tuser);
  assign position   = in_tdata[POS_W-1:0];
  assign entry_data = in_tdata[POS_W +: DATA_W];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;

  assign pos_ext    = (CNT_W + 1)'(position);
  assign cnt_ext    = (CNT_W + 1)'(cnt_r);
  assign ins_pos_ok = (position != '0) && (pos_ext <= cnt_ext + 1'b1);
  assign at_pos_ok  = (position != '0) && (pos_ext <= cnt_ext);
  assign full       = (cnt_r == CNT_W'(DEPTH));

  always_comb begin
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.slot   = SLOT_W'(position - 1'b1);
    status_nxt = ST_BADPOS;
    rdata_nxt  = '0;
    cnt_nxt    = cnt_r;
    unique case (kind)
      KIND_INSERT: begin
        if (!ins_pos_ok) begin
          status_nxt = ST_BADPOS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          cmd.ins    = in_acc;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (at_pos_ok) begin
          status_nxt = ST_OK;
          cmd.rem    = in_acc;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      KIND_READ: begin
        if (at_pos_ok) begin
          status_nxt = ST_OK;
          rdata_nxt  = cell_q[cmd.slot];
        end
      end
      default: begin
        status_nxt = ST_BADPOS;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_q;
    logic [DATA_W-1:0] right_q;
    if (i == 0) begin : g_front
      assign left_q = entry_data;
    end else begin : g_mid
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right_q = cell_q[i];
    end else begin : g_inner
      assign right_q = cell_q[i+1];
    end
    ple_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (SLOT_W'(i)),
      .new_data (entry_data),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      rdata_r  <= rdata_nxt;
      ocnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40 - 2 - DATA_W - CNT_W){1'b0}}, ocnt_r, rdata_r, status_r};

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ins_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd.ins) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the list");

  a_rem_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd.rem) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("remove did not shrink the list");

  a_count_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ocnt_r == cnt_r))
    else $error("reported count differs from held count");

endmodule
